@@ hw/rtl/bni_pkg.sv @@
// shared types and constants for the batch normalization inference core
package bni_pkg;

    localparam int CHANNELS_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int CH_W   = 6;
    localparam int SMP_W  = 16;
    localparam int VAR_W  = 15;
    localparam int EPS_W  = 16;
    localparam int PADR_W = 3;
    localparam int PDAT_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_EPSILON = 1'b0;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    // item as it travels through the root cells
    typedef struct packed {
        t_kind                    kind;
        logic [CH_W-1:0]          channel;
        logic signed [SMP_W-1:0]  sample;
        logic signed [SMP_W-1:0]  gamma;
        logic signed [SMP_W-1:0]  beta;
        logic signed [SMP_W-1:0]  mean;
    } t_item;

    // what a sample carries alongside the divider
    typedef struct packed {
        logic signed [SMP_W-1:0]  gamma;
        logic signed [SMP_W-1:0]  beta;
        logic                     neg;
        logic                     zero;
    } t_post;

endpackage

@@ hw/rtl/bni_sqrt_cell.sv @@
// one digit step of the integer square root, two radicand bits per cell
module bni_sqrt_cell import bni_pkg::*; #(
    parameter int ROOT_W = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_item                 i_item,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    output logic                  o_valid,
    output t_item                 o_item,
    output logic [2*ROOT_W-1:0]   o_rad,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root
);

    logic                  r_valid;
    t_item                 r_item;
    logic [2*ROOT_W-1:0]   r_rad;
    logic [ROOT_W+1:0]     r_rem;
    logic [ROOT_W-1:0]     r_root;

    logic [ROOT_W+1:0]     rem2;
    logic [ROOT_W+1:0]     trial;
    logic                  ge;

    // bring down the next two radicand bits, try root*4+1
    assign rem2  = {i_rem[ROOT_W-1:0], i_rad[2*ROOT_W-1 -: 2]};
    assign trial = {i_root, 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= i_item;
            r_rad  <= {i_rad[2*ROOT_W-3:0], 2'b00};
            r_rem  <= ge ? (rem2 - trial) : rem2;
            r_root <= {i_root[ROOT_W-2:0], ge};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

@@ hw/rtl/bni_div_cell.sv @@
// one quotient bit of an unsigned restoring division
module bni_div_cell import bni_pkg::*; #(
    parameter int QUO_W = 24,
    parameter int DIV_W = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_post             i_post,
    input  logic [DIV_W-1:0]  i_div,
    input  logic [QUO_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_rem,
    input  logic [QUO_W-1:0]  i_quo,
    output logic              o_valid,
    output t_post             o_post,
    output logic [DIV_W-1:0]  o_div,
    output logic [QUO_W-1:0]  o_num,
    output logic [DIV_W-1:0]  o_rem,
    output logic [QUO_W-1:0]  o_quo
);

    logic              r_valid;
    t_post             r_post;
    logic [DIV_W-1:0]  r_div;
    logic [QUO_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;

    logic [DIV_W:0]    rem2;
    logic [DIV_W:0]    diff;
    logic              ge;

    assign rem2 = {i_rem, i_num[QUO_W-1]};
    assign diff = rem2 - {1'b0, i_div};
    assign ge   = (rem2 >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_post <= i_post;
            r_div  <= i_div;
            r_num  <= {i_num[QUO_W-2:0], 1'b0};
            r_rem  <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
            r_quo  <= {i_quo[QUO_W-2:0], ge};
        end
    end

    assign o_valid = r_valid;
    assign o_post  = r_post;
    assign o_div   = r_div;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

@@ hw/rtl/bni_out_buf.sv @@
// two-entry result buffer between the pipeline and the output channel
module bni_out_buf import bni_pkg::*; #(
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_flag,
    input  logic              i_stall,
    output logic              o_space,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_value,
    output logic              o_flag
);

    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic [DATA_W-1:0] r_val0;
    logic [DATA_W-1:0] r_val1;
    logic              r_flg0;
    logic              r_flg1;
    logic              pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_value = r_val0;
    assign o_flag  = r_flg0;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // push only happens with one entry or fewer held
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_count == 2'd2) begin
                r_val0 <= r_val1;
                r_flg0 <= r_flg1;
            end else if (i_push) begin
                r_val0 <= i_value;
                r_flg0 <= i_flag;
            end
        end else if (i_push && r_count == 2'd0) begin
            r_val0 <= i_value;
            r_flg0 <= i_flag;
        end
        if (i_push && !pop && r_count == 2'd1) begin
            r_val1 <= i_value;
            r_flg1 <= i_flag;
        end
    end

endmodule

@@ hw/rtl/batch_norm_inference_core.sv @@
// top level of the fixed-point batch normalization inference core
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  input    | in        | i_valid / o_stall | i_kind i_channel i_sample i_scale_in
//           |           |                   | i_shift_in i_mean_in i_variance_in
//  output   | out       | o_valid / i_stall | o_value o_zero_divisor
//  config   | in        | apb psel/penable  | epsilon at byte address 0
//
//  one item per cycle while o_stall is low; a sample passes the input stage, the root cells,
//  the table read, the dividend stage, the one-bit divider cells and the gamma multiply
//  the whole pipeline moves together and freezes only when both result slots are full
//  synchronous active-low reset clears valid bits, epsilon and the result buffer
//  table entries hold nothing until their channel is loaded
module batch_norm_inference_core import bni_pkg::*; #(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_kind,
    input  logic [CH_W-1:0]         i_channel,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic signed [SMP_W-1:0] i_scale_in,
    input  logic signed [SMP_W-1:0] i_shift_in,
    input  logic signed [SMP_W-1:0] i_mean_in,
    input  logic [VAR_W-1:0]        i_variance_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic                    o_zero_divisor,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADR_W-1:0]       paddr,
    input  logic [PDAT_W-1:0]       pwdata,
    output logic [PDAT_W-1:0]       prdata,
    output logic                    pready
);

    localparam int SUM_W  = EPS_W + 1;
    localparam int RAD_W  = SUM_W + FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int NW     = 2 * ROOT_W;
    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MW     = 3 * SMP_W + ROOT_W;
    localparam int DIFF_W = SMP_W + 1;
    localparam int QUO_W  = SMP_W + FRAC_BITS;
    localparam int PW     = SMP_W + QUO_W + 1;
    localparam int SW     = PW + 1;
    localparam logic signed [PW-1:0] RND = PW'((1 << FRAC_BITS) - 1);
    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    logic en;
    logic space;

    // configuration
    logic [EPS_W-1:0] r_eps;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EPSILON) ? PDAT_W'(r_eps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_EPSILON) begin
            r_eps <= pwdata[EPS_W-1:0];
        end
    end

    assign en      = space;
    assign o_stall = !en;

    // input stage forms the radicand
    logic            r_in_valid;
    t_item           r_in_item;
    logic [NW-1:0]   r_in_rad;
    logic [SUM_W-1:0] sum_ve;

    assign sum_ve = SUM_W'(i_variance_in) + SUM_W'(r_eps);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_item.kind    <= t_kind'(i_kind);
            r_in_item.channel <= i_channel;
            r_in_item.sample  <= i_sample;
            r_in_item.gamma   <= i_scale_in;
            r_in_item.beta    <= i_shift_in;
            r_in_item.mean    <= i_mean_in;
            r_in_rad          <= NW'(sum_ve) << FRAC_BITS;
        end
    end

    // root cells
    logic                sq_valid [0:ROOT_W];
    t_item               sq_item  [0:ROOT_W];
    logic [NW-1:0]       sq_rad   [0:ROOT_W];
    logic [ROOT_W+1:0]   sq_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]   sq_root  [0:ROOT_W];

    assign sq_valid[0] = r_in_valid;
    assign sq_item[0]  = r_in_item;
    assign sq_rad[0]   = r_in_rad;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        bni_sqrt_cell #(.ROOT_W(ROOT_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[k]),
            .i_item  (sq_item[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .o_valid (sq_valid[k+1]),
            .o_item  (sq_item[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1])
        );
    end

    // parameter table: loads write, samples read, in item order
    logic [MW-1:0]  mem [CHANNELS];
    logic [MW-1:0]  r_rd;
    logic           r_tb_valid;
    t_item          r_tb_item;
    logic           r_tb_rng;
    logic [AW-1:0]  tb_addr;
    logic           tb_rng;
    t_item          tb_item;

    assign tb_item = sq_item[ROOT_W];
    assign tb_addr = AW'(tb_item.channel);
    assign tb_rng  = (int'(tb_item.channel) < CHANNELS);

    always_ff @(posedge i_clk) begin
        if (en && sq_valid[ROOT_W] && tb_item.kind == KIND_LOAD && tb_rng) begin
            mem[tb_addr] <= {tb_item.gamma, tb_item.beta, tb_item.mean, sq_root[ROOT_W]};
        end
        if (en) begin
            r_rd <= mem[tb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tb_valid <= 1'b0;
        end else if (en) begin
            r_tb_valid <= sq_valid[ROOT_W] && tb_item.kind == KIND_SAMPLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tb_item <= tb_item;
            r_tb_rng  <= tb_rng;
        end
    end

    // prepare dividend magnitude and sign
    logic [MW-1:0]            ent;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    t_post                    pp_post;
    logic                     r_pp_valid;
    t_post                    r_pp_post;
    logic [ROOT_W-1:0]        r_pp_div;
    logic [QUO_W-1:0]         r_pp_num;

    // a channel beyond the table reads as an all-zero entry
    assign ent  = r_tb_rng ? r_rd : '0;
    assign diff = DIFF_W'(r_tb_item.sample) - DIFF_W'($signed(ent[ROOT_W +: SMP_W]));
    assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    always_comb begin
        pp_post.gamma = ent[ROOT_W + 2*SMP_W +: SMP_W];
        pp_post.beta  = ent[ROOT_W + SMP_W +: SMP_W];
        pp_post.neg   = diff[DIFF_W-1];
        pp_post.zero  = (ent[ROOT_W-1:0] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid <= 1'b0;
        end else if (en) begin
            r_pp_valid <= r_tb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp_post <= pp_post;
            r_pp_div  <= ent[ROOT_W-1:0];
            r_pp_num  <= QUO_W'(mag[SMP_W-1:0]) << FRAC_BITS;
        end
    end

    // divider cells
    logic               dv_valid [0:QUO_W];
    t_post              dv_post  [0:QUO_W];
    logic [ROOT_W-1:0]  dv_div   [0:QUO_W];
    logic [QUO_W-1:0]   dv_num   [0:QUO_W];
    logic [ROOT_W-1:0]  dv_rem   [0:QUO_W];
    logic [QUO_W-1:0]   dv_quo   [0:QUO_W];

    assign dv_valid[0] = r_pp_valid;
    assign dv_post[0]  = r_pp_post;
    assign dv_div[0]   = r_pp_div;
    assign dv_num[0]   = r_pp_num;
    assign dv_rem[0]   = '0;
    assign dv_quo[0]   = '0;

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        bni_div_cell #(.QUO_W(QUO_W), .DIV_W(ROOT_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[k]),
            .i_post  (dv_post[k]),
            .i_div   (dv_div[k]),
            .i_num   (dv_num[k]),
            .i_rem   (dv_rem[k]),
            .i_quo   (dv_quo[k]),
            .o_valid (dv_valid[k+1]),
            .o_post  (dv_post[k+1]),
            .o_div   (dv_div[k+1]),
            .o_num   (dv_num[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quo   (dv_quo[k+1])
        );
    end

    // scale by gamma
    logic signed [QUO_W:0]  qs;
    logic                   r_mu_valid;
    t_post                  r_mu_post;
    logic signed [PW-1:0]   r_mu_prod;
    t_post                  dv_last;

    assign dv_last = dv_post[QUO_W];
    assign qs = dv_last.neg ? -$signed({1'b0, dv_quo[QUO_W]}) : $signed({1'b0, dv_quo[QUO_W]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_valid <= 1'b0;
        end else if (en) begin
            r_mu_valid <= dv_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mu_post <= dv_last;
            r_mu_prod <= dv_last.gamma * qs;
        end
    end

    // truncate toward zero, add beta, saturate
    logic signed [PW-1:0]         adj;
    logic signed [PW-1:0]         scl;
    logic signed [SW-1:0]         sum;
    logic signed [DATA_WIDTH-1:0] res;

    assign adj = r_mu_prod[PW-1] ? (r_mu_prod + RND) : r_mu_prod;
    assign scl = adj >>> FRAC_BITS;
    assign sum = r_mu_post.zero ? SW'(r_mu_post.beta) : (SW'(scl) + SW'(r_mu_post.beta));

    always_comb begin
        if (sum > SAT_HI) begin
            res = SAT_HI[DATA_WIDTH-1:0];
        end else if (sum < SAT_LO) begin
            res = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            res = sum[DATA_WIDTH-1:0];
        end
    end

    bni_out_buf #(.DATA_W(DATA_WIDTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_mu_valid && en),
        .i_value (res),
        .i_flag  (r_mu_post.zero),
        .i_stall (i_stall),
        .o_space (space),
        .o_valid (o_valid),
        .o_value (o_value),
        .o_flag  (o_zero_divisor)
    );

endmodule

@@ hw/rtl/bni_checker.sv @@
// port-level checks for the batch normalization inference core
module bni_checker import bni_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [DATA_WIDTH-1:0] o_value,
    input logic                  o_zero_divisor
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_zero_divisor))
        else $error("result changed while stalled");

    // input backpressure only comes from a full result buffer
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without a pending result");

    // the buffer fills only while the output was blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid) && $past(i_stall))
        else $error("stall rose without output blocked");

    // reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("results survive reset");

endmodule

bind batch_norm_inference_core bni_checker #(.DATA_WIDTH(DATA_WIDTH)) u_bni_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_value        (o_value),
    .o_zero_divisor (o_zero_divisor)
);

@@ verif/tb_batch_norm_inference_core.sv @@
// testbench for the batch normalization inference core: directed table, then random phases
module tb_batch_norm_inference_core;
    import bni_pkg::*;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int DW       = DATA_WIDTH_DEF;
    localparam int SETTLE   = 60;
    localparam int WD_LIMIT = 6000;
    localparam int HOLD_LEN = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_kind = 1'b0;
    logic [CH_W-1:0] i_channel = '0;
    logic signed [SMP_W-1:0] i_sample = '0;
    logic signed [SMP_W-1:0] i_scale_in = '0;
    logic signed [SMP_W-1:0] i_shift_in = '0;
    logic signed [SMP_W-1:0] i_mean_in = '0;
    logic [VAR_W-1:0] i_variance_in = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [DW-1:0] o_value;
    logic o_zero_divisor;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADR_W-1:0] paddr = '0;
    logic [PDAT_W-1:0] pwdata = '0;
    logic [PDAT_W-1:0] prdata;
    logic pready;

    typedef struct {
        t_kind kind;
        logic [CH_W-1:0] ch;
        logic signed [15:0] x;
        logic signed [15:0] gamma;
        logic signed [15:0] beta;
        logic signed [15:0] mean;
        logic [14:0] var_v;
        bit typed;
        logic signed [15:0] t_value;
        bit t_flag;
    } t_bn_row;

    typedef struct {
        logic signed [DW-1:0] value;
        bit flag;
    } t_bn_result;

    // predictor state
    logic signed [15:0] gamma_tab [64];
    logic signed [15:0] beta_tab [64];
    logic signed [15:0] mean_tab [64];
    logic [15:0] std_tab [64];
    bit loaded [64];
    logic [EPS_W-1:0] eps_cur = '0;

    t_bn_result pending_results[$];
    int errors = 0;
    int n_loads = 0, n_samples = 0, n_zero = 0, n_checked = 0;
    int send_idle_pct = 0, stall_pct = 0;
    bit hold_go = 1'b0;
    int hold_left = 0;
    int quiet = 0;

    batch_norm_inference_core DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = longint'(1) << 40;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_bn_result normalize(logic [CH_W-1:0] ch, logic signed [15:0] x);
        t_bn_result res;
        longint q, v, s;
        longint hi, lo;
        hi = (longint'(1) << (DW - 1)) - 1;
        lo = -hi - 1;
        s = longint'(std_tab[ch]);
        if (s == 0) begin
            v = longint'(beta_tab[ch]);
            res.flag = 1'b1;
        end else begin
            q = ((longint'(x) - longint'(mean_tab[ch])) * (longint'(1) << FRAC)) / s;
            v = (longint'(gamma_tab[ch]) * q) / (longint'(1) << FRAC)
                + longint'(beta_tab[ch]);
            res.flag = 1'b0;
        end
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        res.value = v[DW-1:0];
        return res;
    endfunction

    // record an accepted item in the predictor
    task automatic accept_item(t_bn_row r);
        t_bn_result e;
        if (r.kind == KIND_LOAD) begin
            gamma_tab[r.ch] = r.gamma;
            beta_tab[r.ch] = r.beta;
            mean_tab[r.ch] = r.mean;
            std_tab[r.ch] = 16'(root_floor((longint'(r.var_v) + longint'(eps_cur)) << FRAC));
            loaded[r.ch] = 1'b1;
            n_loads++;
        end else begin
            e = normalize(r.ch, r.x);
            if (r.typed) begin
                e.value = r.t_value;
                e.flag = r.t_flag;
            end
            pending_results.push_back(e);
            n_samples++;
        end
    endtask

    task automatic send_item(t_bn_row r);
        // each cycle the sender stays idle with the phase's odds
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= r.kind;
        i_channel <= r.ch;
        i_sample <= r.x;
        i_scale_in <= r.gamma;
        i_shift_in <= r.beta;
        i_mean_in <= r.mean;
        i_variance_in <= r.var_v;
        do @(posedge i_clk); while (o_stall);
        accept_item(r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {PADR_W{1'b0}} | (PADR_W'(REG_EPSILON) << 2);
        pwdata <= {{(PDAT_W-EPS_W){1'b0}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        eps_cur = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick16();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_bn_row random_row();
        t_bn_row r;
        r.ch = CH_W'($urandom);
        r.x = pick16();
        r.gamma = pick16();
        r.beta = pick16();
        r.mean = pick16();
        case ($urandom_range(7))
            0: r.var_v = '0;
            1: r.var_v = '1;
            default: r.var_v = 15'($urandom);
        endcase
        r.typed = 1'b0;
        r.t_value = '0;
        r.t_flag = 1'b0;
        // a sample may only name a channel that holds parameters
        if (!loaded[r.ch] || $urandom_range(99) < 20) r.kind = KIND_LOAD;
        else r.kind = KIND_SAMPLE;
        return r;
    endfunction

    function automatic t_bn_row row(t_kind k, int ch, int x, int g, int b, int m, int v,
                                    bit typed = 0, int tv = 0, bit tf = 0);
        t_bn_row r;
        r.kind = k;
        r.ch = CH_W'(ch);
        r.x = 16'(x);
        r.gamma = 16'(g);
        r.beta = 16'(b);
        r.mean = 16'(m);
        r.var_v = 15'(v);
        r.typed = typed;
        r.t_value = 16'(tv);
        r.t_flag = tf;
        return r;
    endfunction

    // receiver: random stall, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_bn_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation: value %0d zero_divisor %0b",
                       o_value, o_zero_divisor);
                errors++;
            end else begin
                e = pending_results.pop_front();
                n_checked++;
                if (e.flag) n_zero++;
                if (o_value !== e.value) begin
                    $error("value: expected %0d, got %0d", e.value, o_value);
                    errors++;
                end
                if (o_zero_divisor !== e.flag) begin
                    $error("zero_divisor: expected %0b, got %0b", e.flag, o_zero_divisor);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted item, delivered result or register access
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_bn_row dir_rows[$];
        int eps_plan[5];
        int idle_plan[5][2];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero std, saturation both ways, unused fields, plain cases
        dir_rows = '{
            row(KIND_LOAD,   0, 0, 100, 1234, 5, 0),
            row(KIND_SAMPLE, 0, 777, 0, 0, 0, 0, 1, 1234, 1),
            row(KIND_LOAD,   1, 0, 32767, 32767, -32768, 1),
            row(KIND_SAMPLE, 1, 32767, 0, 0, 0, 0, 1, 32767, 0),
            row(KIND_LOAD,   2, 0, -32768, -32768, -32768, 1),
            row(KIND_SAMPLE, 2, 32767, 0, 0, 0, 0, 1, -32768, 0),
            row(KIND_LOAD,   63, -1, 256, 0, 0, 32767),
            row(KIND_SAMPLE, 63, -32768, -1, -1, -1, 32767),
            row(KIND_SAMPLE, 63, 32767, 0, 0, 0, 0),
            row(KIND_LOAD,   5, 0, 256, -10, 100, 256),
            row(KIND_SAMPLE, 5, 100, 0, 0, 0, 0, 1, -10, 0),
            row(KIND_SAMPLE, 5, -32768, 0, 0, 0, 0),
            row(KIND_SAMPLE, 5, 0, 0, 0, 0, 0),
            row(KIND_LOAD,   42, 0, -128, 32767, 32767, 12345),
            row(KIND_SAMPLE, 42, -32768, 0, 0, 0, 0),
            row(KIND_SAMPLE, 42, 1, 0, 0, 0, 0),
            row(KIND_SAMPLE, 0, -32768, 0, 0, 0, 0, 1, 1234, 1)
        };
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        drain();

        eps_plan = '{65535, 0, int'($urandom_range(65535)), 1, int'($urandom_range(65535))};
        idle_plan = '{'{0, 0}, '{86, 0}, '{0, 86}, '{29, 29}, '{0, 0}};
        for (int p = 0; p < 5; p++) begin
            write_epsilon(EPS_W'(eps_plan[p]));
            send_idle_pct = idle_plan[p][0];
            stall_pct = idle_plan[p][1];
            // fill the pipeline against a long receiver hold-off
            if (p == 4) hold_go = 1'b1;
            for (int n = 0; n < 240; n++) begin
                // runs without idling inside each phase
                if (n % 80 == 40) begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end else if (n % 80 == 60) begin
                    send_idle_pct = idle_plan[p][0];
                    stall_pct = idle_plan[p][1];
                end
                send_item(random_row());
            end
            drain();
        end

        $display("covered %0d loads and %0d samples over 6 epsilon settings", n_loads, n_samples);
        $display("checked %0d results, %0d with a zero divisor", n_checked, n_zero);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bni_pkg.sv
hw/rtl/bni_sqrt_cell.sv
hw/rtl/bni_div_cell.sv
hw/rtl/bni_out_buf.sv
hw/rtl/batch_norm_inference_core.sv
hw/rtl/bni_checker.sv
verif/tb_batch_norm_inference_core.sv
